>>> hw/rtl/crhv_pkg.sv
// Shared types and constants for the cache record header verifier.
// Holds the status codes, configuration and verdict structs, magic bytes and CRC-32 step.
// No dependencies.
package crhv_pkg;

  localparam int COUNT_W  = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Header layout offsets
  localparam int OFS_VERSION = 8;
  localparam int OFS_FLAGS   = 10;
  localparam int OFS_GEN     = 12;
  localparam int OFS_LENGTH  = 20;
  localparam int OFS_CRC     = 24;
  localparam int OFS_RSVD    = 28;

  // Magic "LPCACHE1", byte 0 first
  localparam logic [7:0] MAGIC [8] = '{8'h4C, 8'h50, 8'h43, 8'h41,
                                       8'h43, 8'h48, 8'h45, 8'h31};

  // Configuration register indexes
  localparam logic [1:0] CFG_VERSION = 2'd0;
  localparam logic [1:0] CFG_FLAGS   = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HEADER  = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_CRC_ERROR   = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] expected_version;
    logic [15:0] expected_flags;
    logic [19:0] max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] generation;
    logic [19:0] payload_length;
  } verdict_t;

  // One reflected CRC-32 byte update, bit by bit
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cache_record_header_verifier_core.sv
// Cache record header verifier, stream in one byte per beat, one status per record.
//
// Input stream: in_tdata carries one record byte, in_tlast marks the final byte.
// The record is an 8-byte magic, little-endian version, flags, generation,
// payload length and stored CRC, padding up to HEADER_SIZE bytes, then payload.
// Output stream: one beat per record, sent after the final input byte, with the
// status code and, on success only, the generation and payload length.
// Config port: write cfg_wdata to register cfg_addr while cfg_we is high
// (0 expected version, 1 expected flags, 2 max payload bytes); write only
// between records.
// Throughput: one byte per cycle, back to back, while no verdict is stalled.
// The final byte passes the input register, then the CRC step and checks ahead
// of the result register, which holds the verdict beat.
// Stall: while a verdict waits on out_tready the whole pipeline holds and
// in_tready drops; in_tready is high again in the cycle the verdict is taken.
// Reset (rst_n low, synchronous): the pipeline empties, record state rearms and
// the config registers return to version 1, flags 0, max payload 65536.
module cache_record_header_verifier_core #(
  parameter int HEADER_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [2:0] status, [66:3] generation,
                                  // [86:67] payload_length, [87] zero
  // Config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata
);
  import crhv_pkg::*;

  cfg_t       cfg_r;
  logic       en;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  verdict_t   verdict;
  verdict_t   res_r;
  logic       out_vld_r;

  // Advance whenever the result slot is free or draining
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_version  <= 16'd1;
      cfg_r.expected_flags    <= 16'd0;
      cfg_r.max_payload_bytes <= 20'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VERSION: cfg_r.expected_version  <= cfg_wdata[15:0];
        CFG_FLAGS:   cfg_r.expected_flags    <= cfg_wdata[15:0];
        CFG_MAX_LEN: cfg_r.max_payload_bytes <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  crhv_record #(
    .HEADER_SIZE(HEADER_SIZE)
  ) u_record (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (en && vld_r),
    .byte_in (byte_r),
    .last_in (last_r),
    .cfg     (cfg_r),
    .verdict (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r && last_r) begin
      res_r <= verdict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r.payload_length, res_r.generation, res_r.status};

endmodule

>>> hw/rtl/crhv_record.sv
// Per-record state of the header verifier: byte count, running CRC, captured fields.
// Computes the verdict for a final beat from the updated state.
// Depends on crhv_pkg.
module crhv_record #(
  parameter int HEADER_SIZE = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_en,
  input  logic [7:0]         byte_in,
  input  logic               last_in,
  input  crhv_pkg::cfg_t     cfg,
  output crhv_pkg::verdict_t verdict
);
  import crhv_pkg::*;

  localparam logic [COUNT_W-1:0] HDR_CNT = COUNT_W'(HEADER_SIZE);
  localparam logic [32:0]        HDR_SUM = 33'(HEADER_SIZE);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic               magic_ok_r, magic_ok_nxt;
  logic [15:0]        version_r, version_nxt;
  logic [15:0]        flags_r, flags_nxt;
  logic [63:0]        gen_r, gen_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        scrc_r, scrc_nxt;

  logic [4:0]  low;
  logic [4:0]  gen_off;
  logic [4:0]  len_off;
  logic [4:0]  scrc_off;
  logic        crc_en;
  logic [32:0] want_total;

  // Capture header fields and advance the CRC for the current byte
  always_comb begin
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    magic_ok_nxt = magic_ok_r;
    version_nxt  = version_r;
    flags_nxt    = flags_r;
    gen_nxt      = gen_r;
    len_nxt      = len_r;
    scrc_nxt     = scrc_r;

    low      = count_r[4:0];
    gen_off  = low - 5'(OFS_GEN);
    len_off  = low - 5'(OFS_LENGTH);
    scrc_off = low - 5'(OFS_CRC);

    if (count_r < COUNT_W'(OFS_VERSION)) begin
      if (byte_in != MAGIC[count_r[2:0]]) magic_ok_nxt = 1'b0;
    end else if (count_r < COUNT_W'(OFS_FLAGS)) begin
      version_nxt[{count_r[0], 3'b000} +: 8] = byte_in;
    end else if (count_r < COUNT_W'(OFS_GEN)) begin
      flags_nxt[{count_r[0], 3'b000} +: 8] = byte_in;
    end else if (count_r < COUNT_W'(OFS_LENGTH)) begin
      gen_nxt[{gen_off[2:0], 3'b000} +: 8] = byte_in;
    end else if (count_r < COUNT_W'(OFS_CRC)) begin
      len_nxt[{len_off[1:0], 3'b000} +: 8] = byte_in;
    end else if (count_r < COUNT_W'(OFS_RSVD)) begin
      scrc_nxt[{scrc_off[1:0], 3'b000} +: 8] = byte_in;
    end

    crc_en = (count_r >= COUNT_W'(OFS_VERSION) && count_r < COUNT_W'(OFS_CRC)) ||
             (count_r >= HDR_CNT);
    if (crc_en) crc_nxt = crc32_byte(crc_r, byte_in);

    // Saturate at all ones
    if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
  end

  // Check in order: header, version, flags/generation, length, size, CRC
  always_comb begin
    want_total = {1'b0, len_nxt} + HDR_SUM;
    verdict.generation     = '0;
    verdict.payload_length = '0;
    if (count_nxt < HDR_CNT || !magic_ok_nxt) begin
      verdict.status = ST_BAD_HEADER;
    end else if (version_nxt != cfg.expected_version) begin
      verdict.status = ST_UNSUPPORTED;
    end else if (flags_nxt != cfg.expected_flags || gen_nxt == 64'd0) begin
      verdict.status = ST_BAD_HEADER;
    end else if (len_nxt == 32'd0 || len_nxt > {12'd0, cfg.max_payload_bytes}) begin
      verdict.status = ST_BAD_LENGTH;
    end else if ({12'd0, count_nxt} != want_total) begin
      verdict.status = ST_BAD_LENGTH;
    end else if (~crc_nxt != scrc_nxt) begin
      verdict.status = ST_CRC_ERROR;
    end else begin
      verdict.status         = ST_OK;
      verdict.generation     = gen_nxt;
      verdict.payload_length = len_nxt[19:0];
    end
  end

  // Hold record state; rearm on reset and after the final beat
  always_ff @(posedge clk) begin
    if (!rst_n || (beat_en && last_in)) begin
      count_r    <= '0;
      crc_r      <= 32'hFFFF_FFFF;
      magic_ok_r <= 1'b1;
      version_r  <= '0;
      flags_r    <= '0;
      gen_r      <= '0;
      len_r      <= '0;
      scrc_r     <= '0;
    end else if (beat_en) begin
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      magic_ok_r <= magic_ok_nxt;
      version_r  <= version_nxt;
      flags_r    <= flags_nxt;
      gen_r      <= gen_nxt;
      len_r      <= len_nxt;
      scrc_r     <= scrc_nxt;
    end
  end

endmodule

>>> hw/rtl/crhv_checker.sv
// Port-level checks for the cache record header verifier.
// Bound to cache_record_header_verifier_core; depends on crhv_pkg.
module crhv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  import crhv_pkg::*;

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // A verdict from idle follows its final byte via input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("verdict without a final byte");

  // Failure carries no generation or length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[86:3] == '0)
    else $error("fields set on a failed record");

  // Success implies a nonzero generation and length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_OK |->
      out_tdata[66:3] != 64'd0 && out_tdata[86:67] != 20'd0)
    else $error("success with empty generation or length");

  // Status stays within the defined codes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] == ST_OK || out_tdata[2:0] == ST_BAD_HEADER ||
      out_tdata[2:0] == ST_UNSUPPORTED || out_tdata[2:0] == ST_BAD_LENGTH ||
      out_tdata[2:0] == ST_CRC_ERROR)
    else $error("undefined status code");

endmodule

bind cache_record_header_verifier_core crhv_checker u_crhv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
